@@ src/three_link_forward_kinematics_macros.svh @@
// Assertion macros for the arm kinematics block.
// Used by the top level; no other dependencies.
`ifndef THREE_LINK_FORWARD_KINEMATICS_MACROS_SVH
`define THREE_LINK_FORWARD_KINEMATICS_MACROS_SVH
// implication checked every clock outside reset
`define TLFK_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define TLFK_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ src/tlfk_pkg.sv @@
// Package for the arm kinematics block: widths, CORDIC constants, atan table.
// No dependencies.
`timescale 1ns / 1ps
package tlfk_pkg;
  localparam int ANGLE_W = 17;
  localparam int OUT_W = 19;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int LENGTH_BITS_DEF = 16;
  localparam int TABLE_SIZE = 24;
  // vector and angle width in the CORDIC
  localparam int XY_W = 33;
  localparam int Z_W = 32;
  localparam logic signed [XY_W-1:0] GAIN_Q30 = 33'sd652032874;
  localparam logic signed [19:0] TURN_UNITS = 20'sd46080;
  localparam logic signed [19:0] HALF_UNITS = 20'sd23040;
  localparam logic signed [19:0] QUARTER_UNITS = 20'sd11520;
  localparam logic [1:0] REG_LINK_ONE = 2'd0;
  localparam logic [1:0] REG_LINK_TWO = 2'd1;
  localparam logic [1:0] REG_LINK_THREE = 2'd2;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic                   neg;
  } cordic_vec_t;

  function automatic logic signed [Z_W-1:0] atan_entry(input int i);
    logic signed [Z_W-1:0] r;
    unique case (i)
      0: r = 32'sd754974720;  1: r = 32'sd445687602;  2: r = 32'sd235489088;
      3: r = 32'sd119537938;  4: r = 32'sd60000934;   5: r = 32'sd30029717;
      6: r = 32'sd15018523;   7: r = 32'sd7509720;    8: r = 32'sd3754917;
      9: r = 32'sd1877466;    10: r = 32'sd938734;    11: r = 32'sd469367;
      12: r = 32'sd234684;    13: r = 32'sd117342;    14: r = 32'sd58671;
      15: r = 32'sd29335;     16: r = 32'sd14668;     17: r = 32'sd7334;
      18: r = 32'sd3667;      19: r = 32'sd1833;      20: r = 32'sd917;
      21: r = 32'sd458;       22: r = 32'sd229;       23: r = 32'sd115;
      default: r = '0;
    endcase
    return r;
  endfunction
endpackage

@@ src/tlfk_stream_if.sv @@
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
`timescale 1ns / 1ps
interface tlfk_stream_if #(parameter int W = 51);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ src/three_link_forward_kinematics.sv @@
// Three-link planar arm forward kinematics, pipelined CORDIC cell chains.
// Registers: angle sums, start vector, cells, products, tip; one word a cycle.
// The rate is set by the cell chain: every stage advances when the output is free.
// Synchronous active-high reset clears valid bits and link lengths to 0.
// Depends on tlfk_pkg, tlfk_stream_if, tlfk_reduce, tlfk_cordic_cell.
`timescale 1ns / 1ps
`include "three_link_forward_kinematics_macros.svh"
module three_link_forward_kinematics import tlfk_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  tlfk_stream_if.sink   in_ch,
  tlfk_stream_if.source out_ch
);
  localparam int LAT = CORDIC_STAGES + 3;
  localparam int PW = LENGTH_BITS + XY_W + 1;
  localparam int SW = PW + 2;

  logic [LENGTH_BITS-1:0] len [3];
  logic [1:0] ridx;
  assign pready = 1'b1;
  assign ridx = paddr[3:2];
  always_ff @(posedge clk) begin
    if (rst) begin
      len[0] <= '0; len[1] <= '0; len[2] <= '0;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      if (ridx == REG_LINK_ONE) len[0] <= pwdata[LENGTH_BITS-1:0];
      if (ridx == REG_LINK_TWO) len[1] <= pwdata[LENGTH_BITS-1:0];
      if (ridx == REG_LINK_THREE) len[2] <= pwdata[LENGTH_BITS-1:0];
    end
  end
  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      unique case (ridx)
        REG_LINK_ONE:   prdata = 32'(len[0]);
        REG_LINK_TWO:   prdata = 32'(len[1]);
        REG_LINK_THREE: prdata = 32'(len[2]);
        default:        prdata = '0;
      endcase
    end
  end

  // pipeline control: whole chain advances unless the output word is stuck
  logic [LAT:0] vld;
  logic         adv;
  assign adv = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[LAT-1:0], in_ch.valid};
  end
  assign out_ch.valid = vld[LAT];

  logic signed [ANGLE_W-1:0] t1, t2, t3;
  assign t1 = in_ch.data[ANGLE_W-1:0];
  assign t2 = in_ch.data[2*ANGLE_W-1:ANGLE_W];
  assign t3 = in_ch.data[3*ANGLE_W-1:2*ANGLE_W];
  logic signed [19:0] ang [3];
  logic signed [19:0] a0 [3];
  logic signed [OUT_W-1:0] appr [LAT+1];
  always_ff @(posedge clk) begin
    if (adv) begin
      a0[0] <= 20'(t1);
      a0[1] <= 20'(t1) + 20'(t2);
      a0[2] <= 20'(t1) + 20'(t2) + 20'(t3);
      appr[0] <= 19'(t1) + 19'(t2) + 19'(t3);
      for (int i = 1; i <= LAT; i++) appr[i] <= appr[i-1];
    end
  end
  assign ang = a0;

  logic signed [2*PW-1:0] prod [3];
  logic signed [SW-1:0]  sx, sy;
  genvar k, s;
  generate
    for (k = 0; k < 3; k++) begin : g_link
      cordic_vec_t chain [CORDIC_STAGES+1];
      cordic_vec_t start;
      tlfk_reduce u_red (.angle(ang[k]), .vec(start));
      always_ff @(posedge clk) begin
        if (adv) chain[0] <= start;
      end
      for (s = 0; s < CORDIC_STAGES; s++) begin : g_cell
        tlfk_cordic_cell #(.STAGE(s)) u_cell (
          .clk(clk), .en(adv), .vin(chain[s]), .vout(chain[s+1])
        );
      end
      logic signed [PW-1:0] px, py;
      logic signed [XY_W-1:0] cx, cy;
      logic signed [PW-1:0] lx;
      assign cx = chain[CORDIC_STAGES].neg ? -chain[CORDIC_STAGES].x
                                           : chain[CORDIC_STAGES].x;
      assign cy = chain[CORDIC_STAGES].neg ? -chain[CORDIC_STAGES].y
                                           : chain[CORDIC_STAGES].y;
      assign lx = $signed({1'b0, len[k]});
      always_ff @(posedge clk) begin
        if (adv) begin
          px <= PW'(lx * $signed(PW'(cx)));
          py <= PW'(lx * $signed(PW'(cy)));
        end
      end
      assign prod[k] = {px, py};
    end
  endgenerate

  logic signed [PW-1:0] px_k [3], py_k [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      px_k[i] = prod[i][2*PW-1:PW];
      py_k[i] = prod[i][PW-1:0];
    end
    sx = SW'(px_k[0]) + SW'(px_k[1]) + SW'(px_k[2]) + (SW'(1) <<< 29);
    sy = SW'(py_k[0]) + SW'(py_k[1]) + SW'(py_k[2]) + (SW'(1) <<< 29);
  end

  function automatic logic signed [OUT_W-1:0] sat(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] q;
    q = v >>> 30;
    if (q > SW'(262143)) return 19'sd262143;
    if (q < -SW'(262144)) return -19'sd262144;
    return q[OUT_W-1:0];
  endfunction

  logic signed [OUT_W-1:0] ox, oy;
  always_ff @(posedge clk) begin
    if (adv) begin
      ox <= sat(sx);
      oy <= sat(sy);
    end
  end
  assign out_ch.data = {appr[LAT], oy, ox};

  `TLFK_ASSERT_NEXT(a_stall_hold, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(ox))
  `TLFK_ASSERT_IMPL(a_ready_free, !out_ch.valid, in_ch.ready)
  `TLFK_ASSERT_NEXT(a_fill, adv && in_ch.valid, vld[0])
endmodule

@@ src/tlfk_reduce.sv @@
// Angle reduction into +/-90 degrees and CORDIC start vector.
// Depends on tlfk_pkg.
`timescale 1ns / 1ps
module tlfk_reduce import tlfk_pkg::*; (
  input  logic signed [19:0] angle,
  output cordic_vec_t        vec
);
  logic signed [19:0] r;
  logic signed [19:0] q;
  logic               neg;
  always_comb begin
    // a sum of three raw 17-bit angles stays within 4.3 turns of zero,
    // so four conditional corrections each way bring it into range
    r = angle;
    for (int i = 0; i < 4; i++) begin
      if (r > HALF_UNITS) r = r - TURN_UNITS;
    end
    for (int i = 0; i < 4; i++) begin
      if (r <= -HALF_UNITS) r = r + TURN_UNITS;
    end
    neg = 1'b0;
    q = r;
    if (r > QUARTER_UNITS) begin
      q = r - HALF_UNITS;
      neg = 1'b1;
    end else if (r < -QUARTER_UNITS) begin
      q = r + HALF_UNITS;
      neg = 1'b1;
    end
    vec.x = GAIN_Q30;
    vec.y = '0;
    vec.z = {q[14:0], 17'd0};
    vec.neg = neg;
  end
endmodule

@@ src/tlfk_cordic_cell.sv @@
// One CORDIC rotation cell: registered micro-rotation for stage STAGE.
// Depends on tlfk_pkg.
`timescale 1ns / 1ps
module tlfk_cordic_cell import tlfk_pkg::*; #(
  parameter int STAGE = 0
) (
  input  logic        clk,
  input  logic        en,
  input  cordic_vec_t vin,
  output cordic_vec_t vout
);
  cordic_vec_t v_next;
  always_comb begin
    v_next = vin;
    if (STAGE < TABLE_SIZE) begin
      if (vin.z >= 0) begin
        v_next.x = vin.x - (vin.y >>> STAGE);
        v_next.y = vin.y + (vin.x >>> STAGE);
        v_next.z = vin.z - atan_entry(STAGE);
      end else begin
        v_next.x = vin.x + (vin.y >>> STAGE);
        v_next.y = vin.y - (vin.x >>> STAGE);
        v_next.z = vin.z + atan_entry(STAGE);
      end
    end
  end
  always_ff @(posedge clk) begin
    if (en) vout <= v_next;
  end
endmodule

@@ verif/tb_three_link_forward_kinematics.sv @@
// Testbench for three_link_forward_kinematics: directed and randomised joint-angle words checked
// against a CORDIC predictor held in a small scoreboard class.
// Depends on tlfk_pkg, tlfk_stream_if and the block itself.
`timescale 1ns / 1ps
module tb_three_link_forward_kinematics;
  import tlfk_pkg::*;

  typedef struct {
    logic signed [OUT_W-1:0] tip_x;
    logic signed [OUT_W-1:0] tip_y;
    logic signed [OUT_W-1:0] approach;
  } tip_pose_t;

  class pose_scoreboard;
    tip_pose_t   pending_poses[$];
    logic [15:0] link_len[3];
    int          mismatches;
    int          checked;

    function new();
      link_len = '{16'd0, 16'd0, 16'd0};
      mismatches = 0;
      checked = 0;
    endfunction

    // rotation-mode CORDIC on one cumulative angle, Q30 result
    function automatic void rotate_unit(input longint angle, output longint c,
                                        output longint s);
      longint arctan_deg24[24] = '{
        754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
        15018523, 7509720, 3754917, 1877466, 938734, 469367,
        234684, 117342, 58671, 29335, 14668, 7334,
        3667, 1833, 917, 458, 229, 115};
      longint r, x, y, z, xs, ys;
      bit flip;
      r = angle % 46080;
      if (r < 0) r += 46080;
      if (r > 23040) r -= 46080;
      flip = 0;
      if (r > 11520) begin
        r -= 23040;
        flip = 1;
      end else if (r < -11520) begin
        r += 23040;
        flip = 1;
      end
      x = 652032874;
      y = 0;
      z = r * 131072;
      for (int i = 0; i < 16; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x -= ys; y += xs; z -= arctan_deg24[i];
        end else begin
          x += ys; y -= xs; z += arctan_deg24[i];
        end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    function automatic logic signed [OUT_W-1:0] round_q30(input longint q);
      longint v;
      v = (q + (longint'(1) <<< 29)) >>> 30;
      if (v > 262143) v = 262143;
      if (v < -262144) v = -262144;
      return v[OUT_W-1:0];
    endfunction

    function void note_input(input logic [3*ANGLE_W-1:0] word);
      longint joint[3], cum[3], sx, sy, c, s;
      tip_pose_t p;
      joint[0] = longint'($signed(word[ANGLE_W-1:0]));
      joint[1] = longint'($signed(word[2*ANGLE_W-1:ANGLE_W]));
      joint[2] = longint'($signed(word[3*ANGLE_W-1:2*ANGLE_W]));
      cum[0] = joint[0];
      cum[1] = cum[0] + joint[1];
      cum[2] = cum[1] + joint[2];
      sx = 0;
      sy = 0;
      for (int k = 0; k < 3; k++) begin
        rotate_unit(cum[k], c, s);
        sx += longint'(link_len[k]) * c;
        sy += longint'(link_len[k]) * s;
      end
      p.tip_x = round_q30(sx);
      p.tip_y = round_q30(sy);
      p.approach = cum[2][OUT_W-1:0];
      pending_poses.push_back(p);
    endfunction

    function void check_result(input logic [3*OUT_W-1:0] word);
      tip_pose_t e;
      logic signed [OUT_W-1:0] ax, ay, aa;
      ax = word[OUT_W-1:0];
      ay = word[2*OUT_W-1:OUT_W];
      aa = word[3*OUT_W-1:2*OUT_W];
      if (pending_poses.size() == 0) begin
        $error("result word with nothing expected: %0d %0d %0d", ax, ay, aa);
        mismatches++;
        return;
      end
      e = pending_poses.pop_front();
      checked++;
      if (ax !== e.tip_x) begin
        $error("tip_x: expected %0d, got %0d", e.tip_x, ax);
        mismatches++;
      end
      if (ay !== e.tip_y) begin
        $error("tip_y: expected %0d, got %0d", e.tip_y, ay);
        mismatches++;
      end
      if (aa !== e.approach) begin
        $error("approach_angle: expected %0d, got %0d", e.approach, aa);
        mismatches++;
      end
    endfunction
  endclass

  localparam int LIMIT_CYCLES = 400000;

  logic        clk;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;

  tlfk_stream_if #(.W(3*ANGLE_W)) in_if ();
  tlfk_stream_if #(.W(3*OUT_W))   out_if ();

  three_link_forward_kinematics i_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_ch(in_if.sink), .out_ch(out_if.source)
  );

  pose_scoreboard sb;
  int  send_idle_pct, stall_pct, hold_off_cycles;
  int  cycles;
  int  words_sent;

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_if.valid && in_if.ready) sb.note_input(in_if.data);
      if (out_if.valid && out_if.ready) sb.check_result(out_if.data);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // result side: random stalls, plus a long hold-off counted here
  always @(negedge clk) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles--;
      out_if.ready = 1'b0;
    end else begin
      out_if.ready = ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic write_link(input logic [1:0] idx, input logic [15:0] len);
    @(negedge clk);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
    paddr = {idx, 2'b00};
    pwdata = {16'd0, len};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    sb.link_len[idx] = len;
  endtask

  task automatic set_links(input logic [15:0] l1, input logic [15:0] l2,
                           input logic [15:0] l3);
    write_link(REG_LINK_ONE, l1);
    write_link(REG_LINK_TWO, l2);
    write_link(REG_LINK_THREE, l3);
  endtask

  // shoulder sits in the low bits of the word, wrist in the high bits
  task automatic send_angles(input int a1, input int a2, input int a3);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid = 1'b1;
    in_if.data = {ANGLE_W'(a3), ANGLE_W'(a2), ANGLE_W'(a1)};
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
    words_sent++;
  endtask

  function automatic int pick_angle();
    int r;
    r = $urandom_range(99);
    // mostly the legal range, some raw 17-bit patterns and quadrant edges
    if (r < 75) return int'($urandom_range(92160)) - 46080;
    if (r < 90) return int'($urandom);
    return (int'($urandom_range(8)) - 4) * 11520 + int'($urandom_range(2)) - 1;
  endfunction

  task automatic wait_drained();
    in_if.valid = 1'b0;
    while (sb.pending_poses.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    int phase_idle[5]  = '{0, 69, 0, 17, 0};
    int phase_stall[5] = '{0, 0, 69, 17, 0};
    logic [15:0] cfg[5][3] = '{
      '{16'hFFFF, 16'hFFFF, 16'hFFFF}, '{16'd0, 16'hFFFF, 16'd1},
      '{16'd1600, 16'd1200, 16'd400}, '{16'hFFFF, 16'd0, 16'hFFFF},
      '{16'd0, 16'd0, 16'd0}};
    sb = new();
    cycles = 0;
    words_sent = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_off_cycles = 0;
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    paddr = '0; pwdata = '0;
    in_if.valid = 1'b0; in_if.data = '0;
    out_if.ready = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: range ends, quadrant boundaries, raw patterns, wrap-around
    set_links(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_angles(0, 0, 0);
    send_angles(46080, 46080, 46080);
    send_angles(-46080, -46080, -46080);
    send_angles(11520, 0, 0);
    send_angles(11521, -1, 0);
    send_angles(-11520, -1, 1);
    send_angles(23040, 0, 0);
    send_angles(-23040, 23041, 0);
    send_angles(23041, 11519, -11521);
    send_angles('h0FFFF, 'h0FFFF, 'h0FFFF);
    send_angles('h10000, 'h10000, 'h10000);
    send_angles('h1FFFF, 'h00001, 'h15555);
    send_angles('h0AAAA, 'h15555, 'h0AAAA);
    send_angles(5760, 5760, 5760);
    send_angles(-34560, 69120 - 65536, 1);
    wait_drained();
    set_links(16'd1, 16'd0, 16'd0);
    send_angles(0, 0, 0);
    send_angles(23040, 0, 0);
    send_angles(11520, 11520, 11520);
    wait_drained();

    for (int ph = 0; ph < 5; ph++) begin
      set_links(cfg[ph][0], cfg[ph][1], cfg[ph][2]);
      send_idle_pct = phase_idle[ph];
      stall_pct = phase_stall[ph];
      if (ph == 4) begin
        set_links(16'($urandom), 16'($urandom), 16'($urandom));
        hold_off_cycles = 150;  // output blocked, input must back up
      end
      for (int n = 0; n < 206; n++) begin
        if (ph == 0 && n == 103) begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        send_angles(pick_angle(), pick_angle(), pick_angle());
      end
      wait_drained();
    end

    send_idle_pct = 0;
    stall_pct = 0;
    repeat (30) @(posedge clk);
    $display("%0d joint-angle words sent, %0d poses checked over five link settings",
             words_sent, sb.checked);
    $display("idling phases: none, sender, receiver, both, plus one long output hold-off");
    if (sb.mismatches == 0 && sb.pending_poses.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
